>>> src/tbm3_pkg.sv
// Shared types and constants for the thresholded 3x3 binary morphology block.
// Holds the payload structs, register indexes and reset values.
// No dependencies; compile this file first.
package tbm3_pkg;

    // Field widths fixed by the interface.
    localparam int THR_W = 8;
    localparam int DIM_W = 12;
    localparam int POS_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    // Widths of one line-buffer entry.
    localparam int BIN_LINE_W = 2;
    localparam int GROWN_LINE_W = 6;

    // Defaults for the geometry parameters and the smallest legal frame side.
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int MIN_DIM = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // Register reset values.
    localparam logic [THR_W-1:0] THR_RESET = 8'd128;
    localparam logic [DIM_W-1:0] DIM_RESET = 12'd300;

    // One input pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       flush;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             binary_px;
        logic             white_grown;
        logic             black_grown;
        logic             opened;
        logic             closed;
        logic             frame_end;
    } t_out_item;

    // Per-item control decided at transfer time and carried into the window stage.
    typedef struct packed {
        logic             v;
        logic             inner1;
        logic             inner2;
        logic             has_result;
        logic             frame_end;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
    } t_stage_ctl;

endpackage

>>> src/tbm3_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for both line buffers of the morphology block. No dependencies.
module tbm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tbm3_front.sv
// Input stage: binarizes the pixel, tracks the raster position and works out
// where the window centres lie. Depends on tbm3_pkg.
module tbm3_front import tbm3_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  t_in_item                     i_item,
    input  logic [THR_W-1:0]             i_threshold,
    input  logic [DIM_W-1:0]             i_frame_width,
    input  logic [DIM_W-1:0]             i_frame_height,
    output logic                         o_act,
    output t_stage_ctl                   o_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0] o_bin_addr,
    output logic [$clog2(MAX_WIDTH)-1:0] o_grown_addr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT) + 2;
    localparam int LWW = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
    localparam int LHW = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;
    localparam logic [LWW-1:0] W_MIN = LWW'(MIN_DIM);
    localparam logic [LWW-1:0] W_MAX = LWW'(MAX_WIDTH);
    localparam logic [LHW-1:0] H_MIN = LHW'(MIN_DIM);
    localparam logic [LHW-1:0] H_MAX = LHW'(MAX_HEIGHT);
    localparam logic signed [RW:0] ONE_S = (RW+1)'(1);
    localparam logic signed [RW:0] TWO_S = (RW+1)'(2);

    logic [RW-1:0]        r_row;
    logic [CW-1:0]        r_col;
    logic [RW-1:0]        n_row;
    logic [CW-1:0]        n_col;
    logic [LWW-1:0]       w_cfg;
    logic [LWW-1:0]       w_lim;
    logic [LHW-1:0]       h_cfg;
    logic [LHW-1:0]       h_lim;
    logic [CW-1:0]        wm1;
    logic signed [RW:0]   hm1;
    logic signed [RW:0]   ri_s;
    logic signed [RW:0]   r1;
    logic signed [RW:0]   r2;
    logic [CW-1:0]        c1;
    logic [CW-1:0]        c2;
    logic [9:0]           sum;
    logic [9:0]           lim;
    logic                 in_frame;
    logic                 has_result;
    logic                 frame_end;

    // Frame geometry clamped to the legal range.
    always_comb begin
        w_cfg = LWW'(i_frame_width);
        h_cfg = LHW'(i_frame_height);
        if (w_cfg < W_MIN) begin
            w_lim = W_MIN;
        end else if (w_cfg > W_MAX) begin
            w_lim = W_MAX;
        end else begin
            w_lim = w_cfg;
        end
        if (h_cfg < H_MIN) begin
            h_lim = H_MIN;
        end else if (h_cfg > H_MAX) begin
            h_lim = H_MAX;
        end else begin
            h_lim = h_cfg;
        end
        wm1 = CW'(w_lim - LWW'(1));
        hm1 = $signed((RW+1)'(h_lim - LHW'(1)));
    end

    // Window centres: the first stage lags by one row and one column, the second by two.
    always_comb begin
        ri_s = $signed({1'b0, r_row});
        if (r_col != '0) begin
            r1 = ri_s - ONE_S;
            c1 = r_col - CW'(1);
        end else begin
            r1 = ri_s - TWO_S;
            c1 = wm1;
        end
        if (c1 != '0) begin
            r2 = r1 - ONE_S;
            c2 = c1 - CW'(1);
        end else begin
            r2 = r1 - TWO_S;
            c2 = wm1;
        end
        in_frame = ri_s <= hm1;
        has_result = !r2[RW];
        frame_end = has_result && (r2 >= hm1) && (c2 >= wm1);
    end

    // Threshold test: floor(sum / 3) > t is the same as sum > 3 * t + 2.
    always_comb begin
        sum = 10'(i_item.red) + 10'(i_item.green) + 10'(i_item.blue);
        lim = 10'(i_threshold) * 10'd3 + 10'd2;
    end

    // A flush while the raster position is still inside the frame has no effect at all.
    assign o_act = i_take && !(in_frame && i_item.flush);

    always_comb begin
        o_ctl.v = in_frame && (sum > lim);
        o_ctl.inner1 = (r1 >= ONE_S) && (r1 < hm1) && (c1 != '0) && (c1 < wm1);
        o_ctl.inner2 = (r2 >= ONE_S) && (r2 < hm1) && (c2 != '0) && (c2 < wm1);
        o_ctl.has_result = has_result;
        o_ctl.frame_end = frame_end;
        o_ctl.out_row = POS_W'(r2);
        o_ctl.out_col = POS_W'(c2);
    end

    assign o_bin_addr = r_col;
    assign o_grown_addr = c1;

    // Raster position: wraps at the row end and restarts after the frame's last result.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (frame_end) begin
            n_row = '0;
            n_col = '0;
        end else if (r_col >= wm1) begin
            n_row = r_row + RW'(1);
            n_col = '0;
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (o_act) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

>>> src/tbm3_filter.sv
// Window stage: builds both 3x3 windows from the line-buffer columns and
// computes the grow, opening and closing results. Depends on tbm3_pkg.
module tbm3_filter import tbm3_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_stage_ctl              i_ctl,
    input  logic [BIN_LINE_W-1:0]   i_bin_old,
    input  logic [GROWN_LINE_W-1:0] i_grown_old,
    output logic [BIN_LINE_W-1:0]   o_bin_wdata,
    output logic [GROWN_LINE_W-1:0] o_grown_wdata,
    output t_out_item               o_result
);

    // Any of the eight neighbours set; b is the centre column.
    function automatic logic nb_any(input logic [2:0] a, input logic [2:0] b,
                                    input logic [2:0] c);
        return ((a | c) != 3'b000) || (b[2] | b[0]);
    endfunction

    // All eight neighbours set.
    function automatic logic nb_all(input logic [2:0] a, input logic [2:0] b,
                                    input logic [2:0] c);
        return (a == 3'b111) && (c == 3'b111) && b[2] && b[0];
    endfunction

    // Column of one attribute from a column of three triples.
    function automatic logic [2:0] plane(input logic [8:0] col, input int k);
        return {col[6 + k], col[3 + k], col[k]};
    endfunction

    logic [2:0] r_bin [2];
    logic [8:0] r_grown [2];
    logic [2:0] colv1;
    logic [8:0] colv2;
    logic       centre;
    logic       wg;
    logic       bg;
    logic [2:0] e;
    logic [2:0] cen;
    logic       opened;
    logic       closed;

    // First stage: binary window, newest column straight from the line buffer.
    always_comb begin
        colv1 = {i_bin_old, i_ctl.v};
        centre = r_bin[0][1];
        wg = centre;
        bg = centre;
        if (i_ctl.inner1) begin
            wg = centre | nb_any(colv1, r_bin[0], r_bin[1]);
            bg = centre & nb_all(colv1, r_bin[0], r_bin[1]);
        end
        e = {bg, wg, centre};
        o_bin_wdata = {i_bin_old[0], i_ctl.v};
    end

    // Second stage: window of triples; opening shrinks white-grown, closing grows black-grown.
    always_comb begin
        colv2 = {i_grown_old, e};
        o_grown_wdata = {i_grown_old[2:0], e};
        cen = r_grown[0][5:3];
        opened = cen[1];
        closed = cen[2];
        if (i_ctl.inner2) begin
            opened = cen[1] & nb_all(plane(colv2, 1), plane(r_grown[0], 1),
                                     plane(r_grown[1], 1));
            closed = cen[2] | nb_any(plane(colv2, 2), plane(r_grown[0], 2),
                                     plane(r_grown[1], 2));
        end
    end

    always_comb begin
        o_result.out_row = i_ctl.out_row;
        o_result.out_col = i_ctl.out_col;
        o_result.binary_px = cen[0];
        o_result.white_grown = cen[1];
        o_result.black_grown = cen[2];
        o_result.opened = opened;
        o_result.closed = closed;
        o_result.frame_end = i_ctl.frame_end;
    end

    // Window columns shift once per item leaving this stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin[0] <= '0;
            r_bin[1] <= '0;
            r_grown[0] <= '0;
            r_grown[1] <= '0;
        end else if (i_en) begin
            r_bin[1] <= r_bin[0];
            r_bin[0] <= colv1;
            r_grown[1] <= r_grown[0];
            r_grown[0] <= colv2;
        end
    end

endmodule

>>> src/threshold_binary_morphology_3x3_core.sv
// Top level of the thresholded 3x3 binary morphology block: configuration
// registers, line-buffer RAMs, pipeline registers and output register.
// Depends on tbm3_pkg, tbm3_ram, tbm3_front and tbm3_filter.
//
//  Channel  Direction  Handshake                 Payload
//  in       sink       i_in_valid / o_in_stall   i_in_data   (t_in_item)
//  out      source     o_out_valid / i_out_stall o_out_data  (t_out_item)
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// While o_in_stall is low, one pixel is taken per cycle and the line-buffer
// RAMs do one read and one write per cycle. A result passes the window-stage
// and output registers after the transfer of the item causing it, which is item
// p+2W+2 for pixel p. Reset is synchronous; the line buffers need no clearing
// pass after it. A stalled output holds the output register; items still enter
// the window stage, and input stalls only once it holds a waiting result.
module threshold_binary_morphology_3x3_core import tbm3_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [THR_W-1:0]        r_threshold;
    logic [DIM_W-1:0]        r_frame_width;
    logic [DIM_W-1:0]        r_frame_height;
    logic                    in_take;
    logic                    s0_act;
    t_stage_ctl              s0_ctl;
    logic [CW-1:0]           s0_bin_addr;
    logic [CW-1:0]           s0_grown_addr;
    logic                    r_s1_valid;
    t_stage_ctl              r_s1_ctl;
    logic [CW-1:0]           r_s1_bin_addr;
    logic [CW-1:0]           r_s1_grown_addr;
    logic                    r_s1_fwd_grown;
    logic [GROWN_LINE_W-1:0] r_grown_last;
    logic                    out_free;
    logic                    s1_adv;
    logic [BIN_LINE_W-1:0]   bin_rdata;
    logic [GROWN_LINE_W-1:0] grown_rdata;
    logic [GROWN_LINE_W-1:0] grown_old;
    logic [BIN_LINE_W-1:0]   bin_wdata;
    logic [GROWN_LINE_W-1:0] grown_wdata;
    t_out_item               s1_result;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    // Configuration registers; an index beyond the list is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
            r_frame_width <= DIM_RESET;
            r_frame_height <= DIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[THR_W-1:0];
                end
                REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[DIM_W-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[DIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage flow: the window stage retires when the output can take its result
    // or when the item makes no result.
    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_adv = r_s1_valid && (out_free || !r_s1_ctl.has_result);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_take = i_in_valid && !o_in_stall;

    tbm3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (in_take),
        .i_item         (i_in_data),
        .i_threshold    (r_threshold),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_act          (s0_act),
        .o_ctl          (s0_ctl),
        .o_bin_addr     (s0_bin_addr),
        .o_grown_addr   (s0_grown_addr)
    );

    // Line buffers: read on transfer, written back when the item retires.
    tbm3_ram #(
        .WIDTH (BIN_LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_bin_lines (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_bin_addr),
        .i_wdata (bin_wdata),
        .i_re    (s0_act),
        .i_raddr (s0_bin_addr),
        .o_rdata (bin_rdata)
    );

    tbm3_ram #(
        .WIDTH (GROWN_LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_grown_lines (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_grown_addr),
        .i_wdata (grown_wdata),
        .i_re    (s0_act),
        .i_raddr (s0_grown_addr),
        .o_rdata (grown_rdata)
    );

    // Window-stage registers. When the retiring item writes the grown-line entry that
    // the new item reads, the new item takes the written value instead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || s1_adv) begin
            r_s1_valid <= s0_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_act) begin
            r_s1_ctl <= s0_ctl;
            r_s1_bin_addr <= s0_bin_addr;
            r_s1_grown_addr <= s0_grown_addr;
            r_s1_fwd_grown <= s1_adv && (s0_grown_addr == r_s1_grown_addr);
        end
        if (s1_adv) begin
            r_grown_last <= grown_wdata;
        end
    end

    assign grown_old = r_s1_fwd_grown ? r_grown_last : grown_rdata;

    tbm3_filter u_filter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (s1_adv),
        .i_ctl         (r_s1_ctl),
        .i_bin_old     (bin_rdata),
        .i_grown_old   (grown_old),
        .o_bin_wdata   (bin_wdata),
        .o_grown_wdata (grown_wdata),
        .o_result      (s1_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid && r_s1_ctl.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid && r_s1_ctl.has_result) begin
            r_out_data <= s1_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;

    // A new item enters the window stage only when that stage is free or retiring.
    a_s1_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s0_act |-> (!r_s1_valid || s1_adv))
        else $error("item entered an occupied window stage");

    // Consecutive items never touch the same binary line entry.
    a_bin_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_act && s1_adv) |-> (s0_bin_addr != r_s1_bin_addr))
        else $error("binary line read and write clash");

    // A retiring item with a result lands in the output register.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_ctl.has_result) |=> o_out_valid)
        else $error("result lost between window stage and output");

    // A held window-stage item keeps its write address.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_grown_addr)))
        else $error("held window-stage item changed");

endmodule
